// ===== sv/tws_pkg.sv =====
package tws_pkg;

  localparam int CNT_W  = 32;
  localparam int LEN_W  = 5;
  localparam int BUF_W  = 2;
  localparam int NBUF   = 4;
  localparam int NKEPT  = 3;
  localparam int QDEPTH = 2;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_D0 = 8'h30;
  localparam logic [7:0] CH_D9 = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;

  typedef logic [CNT_W-1:0] cnt_t;

  // snapshot of everything a report needs
  typedef struct packed {
    cnt_t                            char_total;
    cnt_t                            word_total;
    cnt_t                            line_total;
    cnt_t                            short_chars;
    cnt_t                            short_line_no;
    cnt_t                            few_words;
    cnt_t                            few_words_line_no;
    logic [NKEPT-1:0][LEN_W-1:0]     kept_len;
    logic [NKEPT-1:0][BUF_W-1:0]     kept_buf;
  } report_t;

  // word buffer write port
  typedef struct packed {
    logic             en;
    logic [BUF_W-1:0] buf_id;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  function automatic logic is_word_byte(input logic [7:0] c);
    return ((c >= CH_D0) && (c <= CH_D9)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
           ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ===== sv/text_word_line_statistics_top.sv =====
// channel   | dir | handshake                    | content
// s_axis    | in  | s_axis_tvalid / s_axis_tready | text byte, end-of-text flag in tuser
// m_axis    | out | m_axis_tvalid / m_axis_tready | totals row, then kept-word characters
//
// a text byte is taken every cycle unless stalled as below; the per-byte counters and
// compares are registered; an end item is accepted at the input and yields 1 + sum of
// kept lengths rows, one row per cycle unless m_axis_tready stalls, from the word buffer
// read port; a queue of two reports sits between; a word byte stalls while its buffer is
// still named by a pending report, an end item stalls while the report queue is full
// reset clears all counters and the report queue; word buffers need no clearing
module text_word_line_statistics_top import tws_pkg::*; #(
  parameter int MAX_WORD = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]   s_axis_tuser,   // [0] end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] char_total, [63:32] word_total, [95:64] line_total,
  // [127:96] shortest_line_chars, [159:128] shortest_line_number,
  // [191:160] fewest_words, [223:192] fewest_words_line_number,
  // [225:224] word_slot, [233:226] word_char, [238:234] word_length, [239] zero
  output logic [239:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser,   // [0] kind
  output logic         m_axis_tlast    // last
);

  logic            q_full, q_valid, push, pop;
  logic [NBUF-1:0] q_busy, bk_busy;
  report_t         push_data, head;
  wr_t             wr;

  tws_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .text_byte_i  (s_axis_tdata),
    .end_of_text_i(s_axis_tuser[0]),
    .q_full_i     (q_full),
    .busy_i       (q_busy | bk_busy),
    .push_o       (push),
    .push_data_o  (push_data),
    .wr_o         (wr)
  );

  tws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head),
    .busy_o     (q_busy)
  );

  tws_back #(.MAX_WORD(MAX_WORD)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .q_valid_i  (q_valid),
    .head_i     (head),
    .pop_o      (pop),
    .busy_o     (bk_busy),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_kind_o (m_axis_tuser[0]),
    .out_last_o (m_axis_tlast)
  );

endmodule

// ===== sv/tws_front.sv =====
module tws_front import tws_pkg::*; #(
  parameter int MAX_WORD = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  input  logic                  q_full_i,
  input  logic [NBUF-1:0]       busy_i,
  output logic                  push_o,
  output report_t               push_data_o,
  output wr_t                   wr_o
);

  cnt_t chars_q, chars_d, words_q, words_d, lines_q, lines_d;
  cnt_t ctl_q, ctl_d, wtl_q, wtl_d;
  cnt_t minc_q, minc_d, mincno_q, mincno_d, minw_q, minw_d, minwno_q, minwno_d;
  logic [LEN_W-1:0]            len_q, len_d;
  logic [NKEPT-1:0][LEN_W-1:0] klen_q, klen_d;
  logic [NKEPT-1:0][BUF_W-1:0] kbuf_q, kbuf_d;
  logic [BUF_W-1:0]            obuf_q, obuf_d;

  logic             wb, room, nl, acc, longer;
  cnt_t             ctl_n, lines_n, wtl_n;
  logic [1:0]       slot;

  assign wb   = is_word_byte(text_byte_i);
  assign room = len_q < LEN_W'(MAX_WORD);
  assign nl   = text_byte_i == CH_LF;

  // a word byte may not land in a buffer that a pending report still reads
  assign in_ready_o = end_of_text_i ? !q_full_i : !(wb && room && busy_i[obuf_q]);
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc && end_of_text_i;

  assign push_data_o = '{char_total: chars_q, word_total: words_q, line_total: lines_q,
                         short_chars: minc_q, short_line_no: mincno_q,
                         few_words: minw_q, few_words_line_no: minwno_q,
                         kept_len: klen_q, kept_buf: kbuf_q};

  // slot to replace: shortest, tie goes to 1 over 0 unless 2 is smaller
  always_comb begin
    if (klen_q[0] < klen_q[1]) begin
      slot = (klen_q[2] < klen_q[0]) ? 2'd2 : 2'd0;
    end else begin
      slot = (klen_q[2] < klen_q[1]) ? 2'd2 : 2'd1;
    end
  end

  assign longer = (klen_q[0] < len_q) || (klen_q[1] < len_q) || (klen_q[2] < len_q);

  always_comb begin
    chars_d  = chars_q;
    words_d  = words_q;
    lines_d  = lines_q;
    ctl_d    = ctl_q;
    wtl_d    = wtl_q;
    minc_d   = minc_q;
    mincno_d = mincno_q;
    minw_d   = minw_q;
    minwno_d = minwno_q;
    len_d    = len_q;
    klen_d   = klen_q;
    kbuf_d   = kbuf_q;
    obuf_d   = obuf_q;
    wr_o     = '0;
    ctl_n    = sat_inc(ctl_q);
    lines_n  = nl ? sat_inc(lines_q) : lines_q;
    wtl_n    = (len_q != '0) ? sat_inc(wtl_q) : wtl_q;
    if (acc && !end_of_text_i) begin
      chars_d = sat_inc(chars_q);
      ctl_d   = ctl_n;
      if (nl) begin
        lines_d = lines_n;
        if ((mincno_q == '0) || (ctl_n < minc_q)) begin
          minc_d   = ctl_n;
          mincno_d = lines_n;
        end
        ctl_d = '0;
      end
      if (wb) begin
        if (room) begin
          wr_o.en     = 1'b1;
          wr_o.buf_id = obuf_q;
          wr_o.idx    = len_q;
          wr_o.data   = text_byte_i;
          len_d       = len_q + LEN_W'(1);
        end
      end else begin
        if (len_q != '0) begin
          words_d = sat_inc(words_q);
        end
        wtl_d = wtl_n;
        if (nl) begin
          if ((minwno_q == '0) || (wtl_n < minw_q)) begin
            minw_d   = wtl_n;
            minwno_d = lines_n;
          end
          wtl_d = '0;
        end
        // keep the word by swapping buffers instead of copying it
        if (longer) begin
          klen_d[slot] = len_q;
          kbuf_d[slot] = obuf_q;
          obuf_d       = kbuf_q[slot];
        end
        len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q  <= '0;
      words_q  <= '0;
      lines_q  <= '0;
      ctl_q    <= '0;
      wtl_q    <= '0;
      minc_q   <= '1;
      mincno_q <= '0;
      minw_q   <= '1;
      minwno_q <= '0;
      len_q    <= '0;
      klen_q   <= '0;
      kbuf_q   <= {BUF_W'(2), BUF_W'(1), BUF_W'(0)};
      obuf_q   <= BUF_W'(3);
    end else begin
      chars_q  <= chars_d;
      words_q  <= words_d;
      lines_q  <= lines_d;
      ctl_q    <= ctl_d;
      wtl_q    <= wtl_d;
      minc_q   <= minc_d;
      mincno_q <= mincno_d;
      minw_q   <= minw_d;
      minwno_q <= minwno_d;
      len_q    <= len_d;
      klen_q   <= klen_d;
      kbuf_q   <= kbuf_d;
      obuf_q   <= obuf_d;
    end
  end

endmodule

// ===== sv/tws_queue.sv =====
module tws_queue import tws_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  report_t         push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output report_t         head_o,
  output logic [NBUF-1:0] busy_o
);

  localparam int PTR_W = $clog2(QDEPTH);

  report_t              ent_q [QDEPTH];
  logic [PTR_W-1:0]     rptr_q, wptr_q;
  logic [PTR_W:0]       cnt_q;
  logic [QDEPTH-1:0]    ent_valid;

  assign full_o  = cnt_q == (PTR_W+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = ent_q[rptr_q];

  // buffers named by queued reports must not be overwritten
  always_comb begin
    busy_o = '0;
    for (int e = 0; e < QDEPTH; e++) begin
      ent_valid[e] = ((PTR_W+1)'(e - int'(rptr_q)) & (PTR_W+1)'(QDEPTH - 1)) < cnt_q;
      if (ent_valid[e]) begin
        for (int k = 0; k < NKEPT; k++) begin
          busy_o[ent_q[e].kept_buf[k]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
      wptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== sv/tws_back.sv =====
module tws_back import tws_pkg::*; #(
  parameter int MAX_WORD = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wr_t             wr_i,
  input  logic            q_valid_i,
  input  report_t         head_i,
  output logic            pop_o,
  output logic [NBUF-1:0] busy_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [239:0]    out_data_o,
  output logic            out_kind_o,
  output logic            out_last_o
);

  localparam int IW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int AW    = BUF_W + IW;
  localparam int DEPTH = NBUF << IW;

  logic [7:0]        mem [DEPTH];
  back_state_e       state_q, state_d;
  report_t           cur_q;
  logic [1:0]        slot_q, slot_d;
  logic [LEN_W-1:0]  idx_q, idx_d, idx_nx;
  logic              p_valid_q, p_kind_q, p_last_q;
  logic [1:0]        p_slot_q;
  logic [LEN_W-1:0]  p_len_q;
  logic [7:0]        rdata_q;
  logic              adv, issue_tot, issue_chr, chr_last, word_end, more;
  logic              nx_kind, nx_last;
  logic [1:0]        nx_slot;
  logic [AW-1:0]     rd_addr;

  assign adv      = !p_valid_q || out_ready_i;
  assign idx_nx   = idx_q + LEN_W'(1);
  assign word_end = idx_nx == cur_q.kept_len[slot_q];
  assign rd_addr  = {cur_q.kept_buf[slot_q], idx_q[IW-1:0]};

  // any nonzero word after the current slot
  always_comb begin
    case (slot_q)
      2'd0:    more = (cur_q.kept_len[1] != '0) || (cur_q.kept_len[2] != '0);
      2'd1:    more = cur_q.kept_len[2] != '0;
      default: more = 1'b0;
    endcase
  end
  assign chr_last = word_end && !more;

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    issue_tot = 1'b0;
    issue_chr = 1'b0;
    nx_kind   = 1'b0;
    nx_last   = 1'b0;
    nx_slot   = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && adv) begin
          pop_o     = 1'b1;
          issue_tot = 1'b1;
          nx_last   = head_i.kept_len == '0;
          idx_d     = '0;
          slot_d    = (head_i.kept_len[0] != '0) ? 2'd0 :
                      (head_i.kept_len[1] != '0) ? 2'd1 : 2'd2;
          if (!nx_last) begin
            state_d = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        if (adv) begin
          issue_chr = 1'b1;
          nx_kind   = 1'b1;
          nx_slot   = slot_q;
          nx_last   = chr_last;
          if (!word_end) begin
            idx_d = idx_nx;
          end else begin
            idx_d  = '0;
            slot_d = ((slot_q == 2'd0) && (cur_q.kept_len[1] != '0)) ? 2'd1 : 2'd2;
          end
          if (chr_last) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    busy_o = '0;
    if (state_q == BK_RUN) begin
      for (int k = 0; k < NKEPT; k++) begin
        busy_o[cur_q.kept_buf[k]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.buf_id, wr_i.idx[IW-1:0]}] <= wr_i.data;
    end
    if (issue_chr) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (issue_tot || issue_chr) begin
      p_kind_q <= nx_kind;
      p_last_q <= nx_last;
      p_slot_q <= nx_slot;
      p_len_q  <= cur_q.kept_len[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      slot_q    <= '0;
      idx_q     <= '0;
      p_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      idx_q   <= idx_d;
      if (adv) begin
        p_valid_q <= issue_tot || issue_chr;
      end
    end
  end

  assign out_valid_o = p_valid_q;
  assign out_kind_o  = p_kind_q;
  assign out_last_o  = p_last_q;

  always_comb begin
    if (p_kind_q) begin
      out_data_o = {1'b0, p_len_q, rdata_q, p_slot_q, 224'd0};
    end else begin
      out_data_o = {16'd0, cur_q.few_words_line_no, cur_q.few_words, cur_q.short_line_no,
                    cur_q.short_chars, cur_q.line_total, cur_q.word_total,
                    cur_q.char_total};
    end
  end

endmodule
